FILE: hw/rtl/tlnce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnce_pkg: shared types and constants
// Character codes, configuration register indexes and the descriptor that
// travels from the front end to the output serializer.
// ----------------------------------------------------------------------------
package tlnce_pkg;

	// Line number geometry.
	localparam int NUMBER_DIGITS = 6;
	localparam int BCD_W         = 4 * NUMBER_DIGITS;
	localparam int DIGIT_IDX_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	// Serializer position: digits, then the tab, then up to three escape bytes.
	localparam int POS_W         = $clog2(NUMBER_DIGITS + 4);

	// Descriptor queue depth.
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_LINE_ENDS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd5;

	// Character codes.
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UPPER_I = 8'h49;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_UPPER_M = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_CTRL_OFFSET = 8'h40;
	localparam logic [7:0] LOW7_MASK = 8'h7F;

	// Work for one accepted item: optional number prefix and one to three
	// body bytes. esc_last holds the body length minus one.
	typedef struct packed {
		logic             num_en;
		logic [BCD_W-1:0] bcd;
		logic [1:0]       esc_last;
		logic [7:0]       esc0;
		logic [7:0]       esc1;
		logic [7:0]       esc2;
	} desc_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tlnce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnce_front: input classifier
// Holds the configuration and the line state, accepts one byte per cycle
// unless the queue is full, and turns it into a serializer queue descriptor.
// ----------------------------------------------------------------------------
module tlnce_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tlnce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                            cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      in_byte,
	output logic                                 q_push,
	output tlnce_pkg::desc_t                     q_desc,
	input  wire logic                            q_full
);
	import tlnce_pkg::*;

	logic             number_all_q;
	logic             number_nonblank_q;
	logic             squeeze_blank_q;
	logic             show_line_ends_q;
	logic             show_tabs_q;
	logic             show_nonprint_q;

	logic             at_start_q;
	logic             cur_empty_q;
	logic             prev_empty_q;
	logic [BCD_W-1:0] bcd_q;

	logic             accept;
	logic             is_nl;
	logic             is_tab;
	logic             drop;
	logic             number_it;
	logic [BCD_W-1:0] bcd_next;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;
	assign is_nl     = (in_byte == CH_NL);
	assign is_tab    = (in_byte == CH_TAB);

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_all_q      <= 1'b0;
			number_nonblank_q <= 1'b0;
			squeeze_blank_q   <= 1'b0;
			show_line_ends_q  <= 1'b0;
			show_tabs_q       <= 1'b0;
			show_nonprint_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUMBER_ALL:      number_all_q      <= cfg_data;
				REG_NUMBER_NONBLANK: number_nonblank_q <= cfg_data;
				REG_SQUEEZE_BLANK:   squeeze_blank_q   <= cfg_data;
				REG_SHOW_LINE_ENDS:  show_line_ends_q  <= cfg_data;
				REG_SHOW_TABS:       show_tabs_q       <= cfg_data;
				REG_SHOW_NONPRINT:   show_nonprint_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A newline right after an empty line is squeezed away entirely.
	assign drop = squeeze_blank_q && at_start_q && prev_empty_q && is_nl;

	assign number_it = number_nonblank_q ? (at_start_q && !is_nl)
	                                     : (at_start_q && number_all_q);

	// Saturating BCD increment: a digit rolls when all lower digits are nine.
	always_comb begin
		logic       carry;
		logic       all_nine;
		logic [3:0] d;
		carry    = 1'b1;
		all_nine = 1'b1;
		bcd_next = bcd_q;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd9) all_nine = 1'b0;
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = bcd_q[4*i +: 4];
			if (carry) bcd_next[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
			carry = carry && (d == 4'd9);
		end
		if (all_nine) bcd_next = bcd_q;
	end

	// Number fields and body bytes of the item, in line end, caret, M- or plain form.
	always_comb begin
		q_desc.num_en   = number_it;
		q_desc.bcd      = number_it ? bcd_next : bcd_q;
		q_desc.esc_last = 2'd0;
		q_desc.esc0     = in_byte;
		q_desc.esc1     = in_byte;
		q_desc.esc2     = in_byte & LOW7_MASK;
		priority if (is_nl && show_line_ends_q) begin
			q_desc.esc_last = 2'd1;
			q_desc.esc0     = CH_DOLLAR;
			q_desc.esc1     = CH_NL;
		end else if (is_tab && show_tabs_q) begin
			q_desc.esc_last = 2'd1;
			q_desc.esc0     = CH_CARET;
			q_desc.esc1     = CH_UPPER_I;
		end else if (show_nonprint_q && in_byte < CH_SPACE && !is_nl && !is_tab) begin
			q_desc.esc_last = 2'd1;
			q_desc.esc0     = CH_CARET;
			q_desc.esc1     = in_byte + CH_CTRL_OFFSET;
		end else if (show_nonprint_q && in_byte == CH_DEL) begin
			q_desc.esc_last = 2'd1;
			q_desc.esc0     = CH_CARET;
			q_desc.esc1     = CH_QMARK;
		end else if (show_nonprint_q && in_byte[7]) begin
			q_desc.esc_last = 2'd2;
			q_desc.esc0     = CH_UPPER_M;
			q_desc.esc1     = CH_DASH;
		end else begin
			q_desc.esc_last = 2'd0;
		end
	end

	assign q_push = accept && !drop;

	// Line state tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			cur_empty_q  <= 1'b1;
			prev_empty_q <= 1'b0;
			bcd_q        <= '0;
		end else if (q_push) begin
			if (number_it) bcd_q <= bcd_next;
			at_start_q <= is_nl;
			if (is_nl) begin
				prev_empty_q <= cur_empty_q;
				cur_empty_q  <= 1'b1;
			end else begin
				if (squeeze_blank_q && at_start_q) prev_empty_q <= 1'b0;
				if (in_byte != CH_SPACE && !is_tab) cur_empty_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/tlnce_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnce_queue: descriptor queue
// A short first-in first-out buffer between the classifier and the
// serializer; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module tlnce_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire tlnce_pkg::desc_t wr_desc,
	output logic       full,
	input  wire logic  rd_en,
	output tlnce_pkg::desc_t rd_desc,
	output logic       valid
);
	import tlnce_pkg::*;

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_desc = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_desc;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + QCNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/tlnce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnce_back: output serializer
// Walks the head descriptor (number digits, tab, body bytes) into an output
// register that the consumer pops, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module tlnce_back (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire tlnce_pkg::desc_t head_desc,
	output logic       head_pop,
	output logic       empty,
	input  wire logic  pop,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import tlnce_pkg::*;

	localparam logic [POS_W-1:0] POS_TAB  = POS_W'(NUMBER_DIGITS);
	localparam logic [POS_W-1:0] POS_BODY = POS_W'(NUMBER_DIGITS + 1);

	logic                   started_q;
	logic [POS_W-1:0]       pos_q;
	logic                   leading_q;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   out_last_q;

	logic                   advance;
	logic [POS_W-1:0]       pos;
	logic                   leading;
	logic [DIGIT_IDX_W-1:0] digit_idx;
	logic [3:0]             digit;
	logic [1:0]             body_idx;
	logic [POS_W-1:0]       body_off;
	logic [7:0]             next_byte;
	logic                   next_last;
	logic                   next_leading;

	assign advance = head_valid && (!out_valid_q || pop);
	assign pos     = started_q ? pos_q : (head_desc.num_en ? '0 : POS_BODY);
	assign leading = started_q ? leading_q : 1'b1;

	assign digit_idx = DIGIT_IDX_W'(NUMBER_DIGITS - 1) - pos[DIGIT_IDX_W-1:0];
	assign body_off  = pos - POS_BODY;
	assign body_idx  = body_off[1:0];

	// Pick the byte at the current position.
	always_comb begin
		digit        = head_desc.bcd[4*digit_idx +: 4];
		if (digit > 4'd9) digit = 4'd9;
		next_byte    = CH_TAB;
		next_last    = 1'b0;
		next_leading = leading;
		if (pos < POS_TAB) begin
			if (leading && digit == 4'd0 && digit_idx != '0) begin
				next_byte = CH_SPACE;
			end else begin
				next_byte    = CH_ZERO + {4'd0, digit};
				next_leading = 1'b0;
			end
		end else if (pos == POS_TAB) begin
			next_byte = CH_TAB;
		end else begin
			unique case (body_idx)
				2'd0:    next_byte = head_desc.esc0;
				2'd1:    next_byte = head_desc.esc1;
				default: next_byte = head_desc.esc2;
			endcase
			next_last = (body_idx == head_desc.esc_last);
		end
	end

	assign head_pop = advance && next_last;

	// Walk position within the current descriptor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pos_q     <= '0;
			leading_q <= 1'b1;
		end else if (advance) begin
			started_q <= !next_last;
			pos_q     <= pos + POS_W'(1);
			leading_q <= next_leading;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/text_line_number_caret_escape.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_number_caret_escape: line numbering and caret escape filter
// Byte stream filter with optional line numbers, blank line squeezing and
// visible line ends, tabs and non-printing bytes.
// ----------------------------------------------------------------------------
// An input byte is taken whenever the descriptor queue has room; the front
// end classifies it at once and may squeeze it away. The serializer emits
// one output byte per cycle while its output register is free or popped:
// one for a plain byte, two or three for an escape, plus seven when a number
// prefix is due, up to ten for a numbered line start. Its one byte per cycle
// sets the sustained rate; a four-entry queue lets input run ahead of output.
// last_of_run marks the final output byte of each input byte.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
module text_line_number_caret_escape (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tlnce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                            cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      in_byte,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [7:0]                           out_byte,
	output logic                                 last_of_run
);
	import tlnce_pkg::*;

	logic  q_push;
	desc_t q_desc;
	logic  q_full;
	logic  head_pop;
	desc_t head_desc;
	logic  head_valid;

	// Front end: configuration, line state and classification.
	tlnce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.q_push    (q_push),
		.q_desc    (q_desc),
		.q_full    (q_full)
	);

	// Queue between front end and serializer.
	tlnce_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_desc (q_desc),
		.full    (q_full),
		.rd_en   (head_pop),
		.rd_desc (head_desc),
		.valid   (head_valid)
	);

	// Output serializer.
	tlnce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_desc   (head_desc),
		.head_pop    (head_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire
